// ----- hdl/htfd_pkg.sv -----
// ----------------------------------------------------------------------------
// htfd_pkg: shared types and constants for the humidity/temperature decoder
// Frame byte positions, CRC-8 settings, conversion scales and the record
// handed from the frame tracker to the conversion stage.
// ----------------------------------------------------------------------------
package htfd_pkg;

    // CRC-8 polynomial x^8 + x^5 + x^4 + 1, seeded with all ones per word
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Byte positions within the six-byte frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Fixed-point conversion: value = (raw * scale) >> 16, less TEMP_OFFSET for temperature
    localparam logic [10:0] TEMP_SCALE  = 11'd1750;
    localparam logic [6:0]  HUM_SCALE   = 7'd100;
    localparam logic [11:0] TEMP_OFFSET = 12'd450;

    // Completed frame, ready for conversion
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        temp_crc_ok;
        logic        hum_crc_ok;
        logic        frame_error;
    } frame_rec_t;

    // Advance the CRC over one byte, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            if (crc[7]) begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ----- hdl/htfd_frame.sv -----
// ----------------------------------------------------------------------------
// htfd_frame: frame tracker
// Follows the byte position, runs the per-word CRC-8, collects the two raw
// words and registers one frame record on the sixth byte.
// ----------------------------------------------------------------------------
module htfd_frame (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_frame_start,
    output logic                 rec_valid,
    input  logic                 rec_ready,
    output htfd_pkg::frame_rec_t rec
);
    import htfd_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [7:0]  hum_hi_reg, hum_hi_next;
    logic [7:0]  hum_lo_reg, hum_lo_next;
    logic        temp_pass_reg, temp_pass_next;
    logic        check_temp_reg;
    logic        rec_valid_reg, rec_valid_next;
    frame_rec_t  rec_reg, rec_next;

    logic        s_accept;
    logic        restart;
    logic [2:0]  pos_eff;
    logic [7:0]  crc_eff;
    logic [7:0]  crc_upd;
    logic        emit;
    logic        hum_ok;

    assign cfg_ready = 1'b1;
    assign s_ready   = !rec_valid_reg || rec_ready;
    assign s_accept  = s_valid && s_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    // Resync on frame start or on an out-of-range position
    assign restart = s_frame_start || (pos_reg > POS_H_CRC);
    assign pos_eff = restart ? POS_T_HI : pos_reg;
    assign crc_eff = restart ? CRC_INIT : crc_reg;
    assign crc_upd = crc8_update(crc_eff, s_data_byte);
    assign hum_ok  = (crc_eff == s_data_byte);

    // Per-byte state update and frame record build
    always_comb begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_hi_next    = hum_hi_reg;
        hum_lo_next    = hum_lo_reg;
        temp_pass_next = temp_pass_reg;
        emit           = 1'b0;
        rec_next       = rec_reg;
        if (s_accept) begin
            pos_next = pos_eff + 3'd1;
            unique case (pos_eff)
                POS_T_HI: begin
                    temp_word_next = {s_data_byte, 8'h00};
                    crc_next       = crc_upd;
                end
                POS_T_LO: begin
                    temp_word_next = {temp_word_reg[15:8], s_data_byte};
                    crc_next       = crc_upd;
                end
                POS_T_CRC: begin
                    temp_pass_next = (crc_eff == s_data_byte);
                    crc_next       = CRC_INIT;
                end
                POS_H_HI: begin
                    hum_hi_next = s_data_byte;
                    crc_next    = crc_upd;
                end
                POS_H_LO: begin
                    hum_lo_next = s_data_byte;
                    crc_next    = crc_upd;
                end
                default: begin
                    // Humidity CRC byte: close the frame
                    emit                 = 1'b1;
                    rec_next.temp_word   = temp_word_reg;
                    rec_next.hum_word    = {hum_hi_reg, hum_lo_reg};
                    rec_next.temp_crc_ok = temp_pass_reg;
                    rec_next.hum_crc_ok  = hum_ok;
                    rec_next.frame_error = !hum_ok || (check_temp_reg && !temp_pass_reg);
                    crc_next             = CRC_INIT;
                    pos_next             = POS_T_HI;
                end
            endcase
        end
    end

    // Record register handshake: load on emit, drop when taken
    always_comb begin
        rec_valid_next = rec_valid_reg;
        if (s_accept && emit) begin
            rec_valid_next = 1'b1;
        end else if (rec_ready) begin
            rec_valid_next = 1'b0;
        end
    end

    // Control and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= POS_T_HI;
            crc_reg        <= CRC_INIT;
            temp_word_reg  <= '0;
            hum_hi_reg     <= '0;
            hum_lo_reg     <= '0;
            temp_pass_reg  <= 1'b0;
            check_temp_reg <= 1'b1;
            rec_valid_reg  <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            temp_word_reg  <= temp_word_next;
            hum_hi_reg     <= hum_hi_next;
            hum_lo_reg     <= hum_lo_next;
            temp_pass_reg  <= temp_pass_next;
            rec_valid_reg  <= rec_valid_next;
            if (cfg_valid && cfg_ready) begin
                check_temp_reg <= cfg_data;
            end
        end
    end

    // Record payload
    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    // Position never leaves the frame
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_H_CRC)
        else $error("byte position out of frame");

    // A start byte always leaves the tracker at the second position
    a_start_resync: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_frame_start |=> pos_reg == POS_T_LO)
        else $error("frame start did not resync position");

    // Closing byte wraps position and reseeds the CRC
    a_close_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !s_frame_start && pos_reg == POS_H_CRC
        |=> pos_reg == POS_T_HI && crc_reg == CRC_INIT && rec_valid_reg)
        else $error("frame close did not wrap");

    // A new record appears only after a closing byte
    a_rec_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(rec_valid_reg) |-> $past(s_accept && emit))
        else $error("record raised without a closing byte");

endmodule

// ----- hdl/htfd_convert.sv -----
// ----------------------------------------------------------------------------
// htfd_convert: unit conversion and result register
// Scales the raw words to tenths of a degree and whole percent and holds
// the result until the receiver takes it.
// ----------------------------------------------------------------------------
module htfd_convert (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rec_valid,
    output logic                 rec_ready,
    input  htfd_pkg::frame_rec_t rec,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [11:0]   m_temperature_tenths,
    output logic [6:0]           m_humidity_percent,
    output logic                 m_temperature_crc_ok,
    output logic                 m_humidity_crc_ok,
    output logic                 m_frame_error
);
    import htfd_pkg::*;

    logic        m_valid_reg, m_valid_next;
    logic [11:0] temp_reg, temp_next;
    logic [6:0]  hum_reg, hum_next;
    logic        temp_ok_reg, hum_ok_reg, err_reg;
    logic [26:0] temp_prod;
    logic [22:0] hum_prod;
    logic        load;

    assign rec_ready = !m_valid_reg || m_ready;
    assign load      = rec_valid && rec_ready;

    // Scale by constant, keep the integer part
    assign temp_prod = 27'(rec.temp_word) * 27'(TEMP_SCALE);
    assign hum_prod  = 23'(rec.hum_word) * 23'(HUM_SCALE);
    assign temp_next = {1'b0, temp_prod[26:16]} - TEMP_OFFSET;
    assign hum_next  = hum_prod[22:16];

    // Result valid: set on load, clear when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, held while stalled
    always_ff @(posedge aclk) begin
        if (load) begin
            temp_reg    <= temp_next;
            hum_reg     <= hum_next;
            temp_ok_reg <= rec.temp_crc_ok;
            hum_ok_reg  <= rec.hum_crc_ok;
            err_reg     <= rec.frame_error;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_temperature_tenths = $signed(temp_reg);
    assign m_humidity_percent   = hum_reg;
    assign m_temperature_crc_ok = temp_ok_reg;
    assign m_humidity_crc_ok    = hum_ok_reg;
    assign m_frame_error        = err_reg;

    // A failed humidity check always flags the frame
    a_hum_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_humidity_crc_ok |-> m_frame_error)
        else $error("humidity CRC failure not flagged");

    // Converted temperature stays in sensor range
    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_temperature_tenths >= -12'sd450) &&
                    (m_temperature_tenths <= 12'sd1299))
        else $error("temperature out of range");

    // Converted humidity stays below full scale
    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_humidity_percent <= 7'd99)
        else $error("humidity out of range");

endmodule

// ----- hdl/humidity_temp_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top: sensor measurement frame decoder
// Decodes six-byte temperature/humidity frames with per-word CRC-8 checks.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one frame byte per transfer (s_data_byte), s_frame_start
//   marks byte 0 and drops any partial frame. Bytes run temperature high,
//   low, CRC, humidity high, low, CRC; after the sixth the next byte starts
//   a new frame even without s_frame_start.
//   m_ channel: one result per frame, after the transfer of the sixth byte:
//   temperature in tenths of a degree, humidity in percent, both CRC pass
//   flags and an error flag. Values are converted even on CRC failure.
//   cfg_ channel: cfg_data enables the temperature CRC in the error flag
//   (reset 1); always ready, write only while no frame is in flight.
//   Throughput: one byte per cycle while s_ready is high. The sixth byte
//   passes through the frame record register, then the conversion/result
//   register, before m_valid rises for its result.
//   Stall: each of the two registers loads when empty or being emptied, so
//   bytes keep flowing while one result waits; s_ready drops only when both
//   hold a result and m_ready is low.
//   Reset: synchronous, active low; clears position and CRC state, empties
//   both registers and sets the temperature check enable.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_frame_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [11:0] m_temperature_tenths,
    output logic [6:0]         m_humidity_percent,
    output logic               m_temperature_crc_ok,
    output logic               m_humidity_crc_ok,
    output logic               m_frame_error
);
    import htfd_pkg::*;

    logic       rec_valid;
    logic       rec_ready;
    frame_rec_t rec;

    // Frame tracking and CRC
    htfd_frame u_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_frame_start (s_frame_start),
        .rec_valid     (rec_valid),
        .rec_ready     (rec_ready),
        .rec           (rec)
    );

    // Conversion and result register
    htfd_convert u_convert (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .rec_valid            (rec_valid),
        .rec_ready            (rec_ready),
        .rec                  (rec),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_temperature_tenths (m_temperature_tenths),
        .m_humidity_percent   (m_humidity_percent),
        .m_temperature_crc_ok (m_temperature_crc_ok),
        .m_humidity_crc_ok    (m_humidity_crc_ok),
        .m_frame_error        (m_frame_error)
    );

endmodule

// ----- bench/tb_humidity_temp_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// tb_humidity_temp_frame_decoder_top: frame decoder self-checking bench
// Streams six-byte temperature/humidity frames through the byte channel.
// The stream mixes good and corrupted CRCs, partial frames, mid-frame
// restarts and stray bytes. A scoreboard tracks the frame position and both
// CRCs, works out each converted reading and compares it field by field with
// what the result channel delivers. Both channels pause in random bursts, and
// the temperature check enable is toggled between traffic phases.
// ----------------------------------------------------------------------------
module tb_humidity_temp_frame_decoder_top;
    import htfd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TEMP_MULT   = 1750;
    localparam int TEMP_BIAS   = 450;
    localparam int HUM_MULT    = 100;

    logic               aclk;
    logic               aresetn       = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic               cfg_data      = 1'b1;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [7:0]         s_data_byte   = 8'h00;
    logic               s_frame_start = 1'b0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic signed [11:0] m_temperature_tenths;
    logic [6:0]         m_humidity_percent;
    logic               m_temperature_crc_ok;
    logic               m_humidity_crc_ok;
    logic               m_frame_error;

    // Pacing controls, frame fill and quiet-cycle counters used by the bench
    bit idle_on    = 1'b1;
    int gap_span   = 0;
    int gap_odds   = 0;
    int frame_fill = 0;
    int quiet_cycles = 0;

    humidity_temp_frame_decoder_top u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_data_byte          (s_data_byte),
        .s_frame_start        (s_frame_start),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_temperature_tenths (m_temperature_tenths),
        .m_humidity_percent   (m_humidity_percent),
        .m_temperature_crc_ok (m_temperature_crc_ok),
        .m_humidity_crc_ok    (m_humidity_crc_ok),
        .m_frame_error        (m_frame_error)
    );

    // Fold one byte into the CRC, one data bit per shift, MSB first
    function automatic logic [7:0] crc8_of_byte(input logic [7:0] crc_in,
                                                input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc_in;
        for (int k = 7; k >= 0; k--) begin
            fb = c[7] ^ data[k];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_of_byte(crc8_of_byte(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    typedef struct {
        logic signed [11:0] temp_tenths;
        logic [6:0]         hum_pct;
        logic               temp_ok;
        logic               hum_ok;
        logic               err;
    } reading_t;

    // Frame tracker plus queue of readings still owed by the block
    class frame_scoreboard;
        logic [2:0]  byte_pos;
        logic [7:0]  crc_acc;
        logic [15:0] temp_word;
        logic [7:0]  hum_hi;
        logic [7:0]  hum_lo;
        logic        temp_passed;
        logic        temp_check_en;
        reading_t    due_readings[$];
        int          mismatches;

        function new();
            byte_pos      = POS_T_HI;
            crc_acc       = CRC_INIT;
            temp_word     = '0;
            hum_hi        = '0;
            hum_lo        = '0;
            temp_passed   = 1'b0;
            temp_check_en = 1'b1;
            mismatches    = 0;
        endfunction

        function void set_temp_check(input logic en);
            temp_check_en = en;
        endfunction

        function int pending();
            return due_readings.size();
        endfunction

        // Advance the frame by one transferred byte; queue a reading on the last
        function void decode_byte(input logic [7:0] b, input logic start);
            logic [2:0]  p;
            logic [31:0] t_prod;
            logic [31:0] h_prod;
            reading_t    r;
            p = byte_pos;
            if (start || p > POS_H_CRC) begin
                p       = POS_T_HI;
                crc_acc = CRC_INIT;
            end
            case (p)
                POS_T_HI: begin
                    temp_word = {b, 8'h00};
                    crc_acc   = crc8_of_byte(crc_acc, b);
                end
                POS_T_LO: begin
                    temp_word[7:0] = b;
                    crc_acc        = crc8_of_byte(crc_acc, b);
                end
                POS_T_CRC: begin
                    temp_passed = (crc_acc == b);
                    crc_acc     = CRC_INIT;
                end
                POS_H_HI: begin
                    hum_hi  = b;
                    crc_acc = crc8_of_byte(crc_acc, b);
                end
                POS_H_LO: begin
                    hum_lo  = b;
                    crc_acc = crc8_of_byte(crc_acc, b);
                end
                default: begin
                    t_prod        = 32'(temp_word) * 32'(TEMP_MULT);
                    h_prod        = 32'({hum_hi, hum_lo}) * 32'(HUM_MULT);
                    r.temp_tenths = 12'((t_prod >> 16) - 32'(TEMP_BIAS));
                    r.hum_pct     = 7'(h_prod >> 16);
                    r.temp_ok     = temp_passed;
                    r.hum_ok      = (crc_acc == b);
                    r.err         = !r.hum_ok || (temp_check_en && !temp_passed);
                    due_readings.push_back(r);
                    crc_acc  = CRC_INIT;
                    byte_pos = POS_T_HI;
                    return;
                end
            endcase
            byte_pos = p + 3'd1;
        endfunction

        function void check_field(input string name, input logic signed [31:0] want,
                                  input logic signed [31:0] got);
            if (got !== want) begin
                mismatches++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        // Match a delivered reading against the oldest one owed
        function void compare_reading(input logic signed [11:0] temp_tenths,
                                      input logic [6:0] hum_pct, input logic temp_ok,
                                      input logic hum_ok, input logic err);
            reading_t exp_r;
            if (due_readings.size() == 0) begin
                mismatches++;
                $error("unexpected reading: temperature_tenths %0d humidity_percent %0d",
                       temp_tenths, hum_pct);
                return;
            end
            exp_r = due_readings.pop_front();
            check_field("temperature_tenths", exp_r.temp_tenths, temp_tenths);
            check_field("humidity_percent", exp_r.hum_pct, hum_pct);
            check_field("temperature_crc_ok", exp_r.temp_ok, temp_ok);
            check_field("humidity_crc_ok", exp_r.hum_ok, hum_ok);
            check_field("frame_error", exp_r.err, err);
        endfunction
    endclass

    frame_scoreboard sb = new();

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Observe transfers on both data channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.decode_byte(s_data_byte, s_frame_start);
            end
            if (m_valid && m_ready) begin
                sb.compare_reading(m_temperature_tenths, m_humidity_percent,
                                   m_temperature_crc_ok, m_humidity_crc_ok, m_frame_error);
            end
        end
    end

    // Abort when no channel has moved anything for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Result sink: stall bursts at a rate that changes from stretch to stretch
    initial begin : sink_pacing
        int odds;
        int span;
        odds = 0;
        span = 0;
        forever begin
            @(posedge aclk);
            if (span == 0) begin
                span = $urandom_range(50, 300);
                odds = $urandom_range(0, 3);
            end
            span--;
            if (idle_on && odds != 0 && $urandom_range(0, 4 * odds) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Present one byte, optionally after a gap, and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic st);
        if (gap_span == 0) begin
            gap_span = $urandom_range(20, 200);
            gap_odds = $urandom_range(0, 3);
        end
        gap_span--;
        if (idle_on && gap_odds != 0 && $urandom_range(0, 3 * gap_odds) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_frame_start <= st;
        if (st) begin
            frame_fill = 0;
        end
        frame_fill = (frame_fill == 5) ? 0 : frame_fill + 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Send the first n_bytes of a frame, corrupting either CRC on request
    task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input bit t_bad, input bit h_bad, input bit lead_start,
                              input int n_bytes);
        logic [7:0] fb [6];
        fb[0] = t_word[15:8];
        fb[1] = t_word[7:0];
        fb[2] = word_crc(t_word) ^ (t_bad ? 8'($urandom_range(1, 255)) : 8'h00);
        fb[3] = h_word[15:8];
        fb[4] = h_word[7:0];
        fb[5] = word_crc(h_word) ^ (h_bad ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = 0; i < n_bytes; i++) begin
            send_byte(fb[i], (i == 0) && lead_start);
        end
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Finish any open frame, drop valid and let all readings come out
    task automatic drain();
        while (frame_fill != 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_temp_check(input logic en);
        cfg_valid <= 1'b1;
        cfg_data  <= en;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_temp_check(en);
    endtask

    // Mostly whole frames with random words, the rest partial frames and stray bytes
    task automatic run_phase(input int n_items);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                send_frame(pick_word(), pick_word(), $urandom_range(0, 3) == 0,
                           $urandom_range(0, 3) == 0,
                           (frame_fill == 0) ? ($urandom_range(0, 2) != 0)
                                             : ($urandom_range(0, 9) != 0), 6);
                sent += 6;
            end else if (kind < 92) begin
                len = $urandom_range(1, 5);
                send_frame(pick_word(), pick_word(), 1'b0, 1'b0,
                           $urandom_range(0, 3) != 0, len);
                sent += len;
            end else begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent += 1;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Extreme words with good CRCs, temperature check at its reset value
        send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 6);
        // Next frame without a start flag, bad temperature CRC
        send_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 6);
        // Partial frame dropped by a start flag mid-frame, then bad humidity CRC
        send_frame(16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b1, 3);
        send_frame(16'h6666, 16'h8000, 1'b0, 1'b1, 1'b1, 6);
        drain();

        write_temp_check(1'b0);
        run_phase(460);
        drain();
        write_temp_check(1'b1);
        run_phase(460);
        drain();
        write_temp_check(1'b0);
        run_phase(460);
        drain();

        // Closing phase at full rate on both sides
        write_temp_check(1'b1);
        idle_on = 1'b0;
        run_phase(460);
        drain();

        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/htfd_pkg.sv
hdl/htfd_frame.sv
hdl/htfd_convert.sv
hdl/humidity_temp_frame_decoder_top.sv
bench/tb_humidity_temp_frame_decoder_top.sv
